// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file crs_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for an implication that must hold whenever its trigger is seen.
`define ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/crs_pkg.sv =====
// Shared types and constants for the clip rectangle stack.
// No dependencies; imported by every module of the block except crs_ram.
package crs_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int COORD_BITS  = 16;
    localparam int COORD_W     = 16;
    localparam int COORD_PAD   = COORD_W - COORD_BITS;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_OUT_W = 8;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord lo_x;
        t_coord lo_y;
        t_coord hi_x;
        t_coord hi_y;
    } t_rect;

    localparam int RECT_W = $bits(t_rect);

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_RESET = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic    push;       // intersect with top, write new entry
        logic    pop_rd;     // drop top, start read of new top
        logic    pop_wr;     // take read data as new top
        logic    load_base;  // replace stack with given rectangle
        logic    load_out;   // capture result into output register
        t_status status;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic at_base;
    } t_dp_stat;

    // Keep the low COORD_BITS of a raw field and sign-extend them.
    function automatic t_coord coord_in(input logic [COORD_W-1:0] raw);
        t_coord shifted;
        shifted = t_coord'(raw << COORD_PAD);
        return shifted >>> COORD_PAD;
    endfunction

endpackage

// ===== sv/clip_rect_intersect_stack_unit.sv =====
// Top level of the clip rectangle stack (scissor stack).
// Depends on crs_pkg, crs_ctrl, crs_dp (which holds crs_ram).
//
// Keeps a stack of up to STACK_DEPTH clip rectangles; the top entry is the
// current clip. A push item (action 0) intersects its rectangle with the top
// (lower bounds max, upper bounds min) and pushes the result; a pop item
// (action 1) drops the top; a reset item (action 2) makes its rectangle the
// only entry. Action 3 changes nothing. Each item yields exactly one result
// item: the new top, a nonempty flag (positive area), a status (ok, push
// overflow ignored, pop underflow ignored) and the depth after the item.
// Coordinates are read as COORD_BITS-bit two's complement values.
// Timing: push, reset, action 3 and rejected push/pop show their result in the
// cycle after acceptance; a successful pop passes the RAM read and then S_POP,
// as the new top comes out of the synchronous stack RAM in the cycle after its
// read. The block works on one item at a time: a new item is accepted in S_IDLE
// once the result register is empty or being drained in the same cycle, so push
// and reset run at one item per cycle while drained; S_POP holds off new items.
// After reset the stack holds one all-zero entry; there is no clearing pass,
// the base entry carries its own valid flag.
module clip_rect_intersect_stack_unit
    import crs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic signed [15:0]     i_left,
    input  logic signed [15:0]     i_top,
    input  logic signed [15:0]     i_right,
    input  logic signed [15:0]     i_bottom,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_clip_left,
    output logic signed [15:0]     o_clip_top,
    output logic signed [15:0]     o_clip_right,
    output logic signed [15:0]     o_clip_bottom,
    output logic                   o_nonempty,
    output logic [1:0]             o_status,
    output logic [DEPTH_OUT_W-1:0] o_depth_now
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_rect    out_rect;
    t_status  out_status;

    // Sequencing: accept, decode action, wait out the RAM read on pop.
    crs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Stack storage, intersection and the result register.
    crs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_left      (i_left),
        .i_top       (i_top),
        .i_right     (i_right),
        .i_bottom    (i_bottom),
        .o_rect      (out_rect),
        .o_nonempty  (o_nonempty),
        .o_status    (out_status),
        .o_depth_now (o_depth_now)
    );

    assign o_clip_left   = out_rect.lo_x;
    assign o_clip_top    = out_rect.lo_y;
    assign o_clip_right  = out_rect.hi_x;
    assign o_clip_bottom = out_rect.hi_y;
    assign o_status      = out_status;

endmodule

// ===== sv/crs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/crs_ctrl.sv =====
// Controller for the clip rectangle stack: handshakes and sequencing.
// Depends on crs_pkg.
module crs_ctrl
    import crs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    in_ready;
    logic    accept;
    t_dp_cmd cmd;

    // Output register is free next cycle if empty now or drained now.
    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_out = 1'b1;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (i_stat.full) begin
                                cmd.status = ST_OVERFLOW;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (i_stat.at_base) begin
                                cmd.status = ST_UNDERFLOW;
                            end else begin
                                cmd.pop_rd   = 1'b1;
                                cmd.load_out = 1'b0;
                                n_state      = S_POP;
                            end
                        end
                        ACT_RESET: begin
                            cmd.load_base = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                cmd.pop_wr   = 1'b1;
                cmd.load_out = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== sv/crs_dp.sv =====
// Datapath for the clip rectangle stack: top register, count, stack memory,
// intersection logic and output register. Depends on crs_pkg and crs_ram.
module crs_dp
    import crs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [COORD_W-1:0]     i_left,
    input  logic [COORD_W-1:0]     i_top,
    input  logic [COORD_W-1:0]     i_right,
    input  logic [COORD_W-1:0]     i_bottom,
    output t_rect                  o_rect,
    output logic                   o_nonempty,
    output t_status                o_status,
    output logic [DEPTH_OUT_W-1:0] o_depth_now
);

    t_rect             r_top, n_top;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_base_valid, n_base_valid;

    t_rect             given;
    t_rect             isect;
    t_rect             rd_rect;
    logic [CNT_W-1:0]  cnt_m2;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_rect             ram_wdata;

    t_rect                  r_o_rect;
    logic                   r_o_nonempty;
    t_status                r_o_status;
    logic [DEPTH_OUT_W-1:0] r_o_depth;

    always_comb begin
        given.lo_x = coord_in(i_left);
        given.lo_y = coord_in(i_top);
        given.hi_x = coord_in(i_right);
        given.hi_y = coord_in(i_bottom);

        // Lower bounds take the max, upper bounds the min.
        isect.lo_x = (r_top.lo_x < given.lo_x) ? given.lo_x : r_top.lo_x;
        isect.lo_y = (r_top.lo_y < given.lo_y) ? given.lo_y : r_top.lo_y;
        isect.hi_x = (r_top.hi_x > given.hi_x) ? given.hi_x : r_top.hi_x;
        isect.hi_y = (r_top.hi_y > given.hi_y) ? given.hi_y : r_top.hi_y;
    end

    assign cnt_m2    = r_count - CNT_W'(2);
    assign ram_we    = i_cmd.push || i_cmd.load_base;
    assign ram_waddr = i_cmd.push ? r_count[ADDR_W-1:0] : '0;
    assign ram_wdata = i_cmd.push ? isect : given;

    crs_ram #(
        .WIDTH (RECT_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (rd_rect)
    );

    always_comb begin
        n_top        = r_top;
        n_count      = r_count;
        n_base_valid = r_base_valid;
        if (i_cmd.push) begin
            n_top   = isect;
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.pop_rd) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.pop_wr) begin
            // Base entry never loaded since reset reads as all zeros.
            if (r_count == CNT_W'(1) && !r_base_valid) begin
                n_top = '0;
            end else begin
                n_top = rd_rect;
            end
        end
        if (i_cmd.load_base) begin
            n_top        = given;
            n_count      = CNT_W'(1);
            n_base_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top        <= '0;
            r_count      <= CNT_W'(1);
            r_base_valid <= 1'b0;
        end else begin
            r_top        <= n_top;
            r_count      <= n_count;
            r_base_valid <= n_base_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_rect     <= n_top;
            r_o_nonempty <= (n_top.lo_x < n_top.hi_x) && (n_top.lo_y < n_top.hi_y);
            r_o_status   <= i_cmd.status;
            r_o_depth    <= DEPTH_OUT_W'(n_count);
        end
    end

    assign o_stat.full    = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.at_base = (r_count == CNT_W'(1));
    assign o_rect         = r_o_rect;
    assign o_nonempty     = r_o_nonempty;
    assign o_status       = r_o_status;
    assign o_depth_now    = r_o_depth;

endmodule

// ===== sv/crs_checker.sv =====
// Port-level checks for clip_rect_intersect_stack_unit, bound to the top.
// Depends on crs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crs_checker
    import crs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [1:0]             i_action,
    input logic signed [15:0]     i_left,
    input logic signed [15:0]     i_top,
    input logic signed [15:0]     i_right,
    input logic signed [15:0]     i_bottom,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [15:0]     o_clip_left,
    input logic signed [15:0]     o_clip_top,
    input logic signed [15:0]     o_clip_right,
    input logic signed [15:0]     o_clip_bottom,
    input logic                   o_nonempty,
    input logic [1:0]             o_status,
    input logic [DEPTH_OUT_W-1:0] o_depth_now
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // Stalled result holds.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_clip_left) && $stable(o_depth_now) && $stable(o_status), "result changed while stalled")

    // A new result appears only as the outcome of a recently accepted item.
    `ASSERT_CLK(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(in_acc) || $past(in_acc, 2), "result without an accepted item")

    // Overflow is reported only with a full stack.
    `ASSERT_IMPL(a_ovf_full, i_clk, i_rst_n, o_out_valid && o_status == ST_OVERFLOW, o_depth_now == DEPTH_OUT_W'(STACK_DEPTH), "overflow below full depth")

    // Underflow is reported only at the base entry.
    `ASSERT_IMPL(a_unf_base, i_clk, i_rst_n, o_out_valid && o_status == ST_UNDERFLOW, o_depth_now == DEPTH_OUT_W'(1), "underflow above base entry")

    // Area flag agrees with the rectangle shown.
    `ASSERT_IMPL(a_area, i_clk, i_rst_n, o_out_valid, o_nonempty == ((o_clip_left < o_clip_right) && (o_clip_top < o_clip_bottom)), "nonempty flag mismatch")

endmodule

bind clip_rect_intersect_stack_unit crs_checker u_crs_checker (.*);
